// File: hdl/length_prefix_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// Length prefix deframer assertion macros
// Shared concurrent assertion forms for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Length prefix deframer package
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LENGTH_W = 32;
   localparam int unsigned IDX_W    = 2;

   localparam logic [LENGTH_W-1:0] HDR_BYTES = LENGTH_W'(4);
   localparam logic [IDX_W-1:0]    HDR_LAST  = IDX_W'(HDR_BYTES - 1);
   localparam logic [LENGTH_W-1:0] ONE_LEFT  = LENGTH_W'(1);

   typedef enum logic [1:0] {
      LPD_HEADER,
      LPD_PAYLOAD,
      LPD_CLOSED
   } lpd_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   payload_byte;
      logic                last_byte;
      logic [LENGTH_W-1:0] payload_length;
      logic                bad_header;
   } lpd_result_type;

endpackage

// File: hdl/lpd_parse.sv
// ----------------------------------------------------------------------------
// Length prefix deframer parser
// Header assembly, length check and payload countdown for each byte.
// ----------------------------------------------------------------------------
module lpd_parse
   import lpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_accept,
   input  logic [BYTE_W-1:0]   item_byte,
   output logic                result_valid,
   output lpd_result_type      result
);

   lpd_state_type              state_ff, state_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [LENGTH_W-BYTE_W-1:0] total_ff, total_in;
   logic [LENGTH_W-1:0]        plen_ff, plen_in;
   logic [LENGTH_W-1:0]        remain_ff, remain_in;
   logic [LENGTH_W-1:0]        header_word;
   logic                       last;

   assign header_word = {item_byte, total_ff};
   assign last        = (remain_ff == ONE_LEFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LPD_HEADER;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
      total_ff  <= total_in;
      plen_ff   <= plen_in;
      remain_ff <= remain_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      plen_in      = plen_ff;
      remain_in    = remain_ff;
      result_valid = 1'b0;
      result       = '0;
      case (state_ff)
         LPD_HEADER: begin
            if (item_accept) begin
               total_in = header_word[LENGTH_W-1:BYTE_W];
               idx_in   = idx_ff + IDX_W'(1);
               if (idx_ff == HDR_LAST) begin
                  if (header_word <= HDR_BYTES) begin
                     state_in          = LPD_CLOSED;
                     result_valid      = 1'b1;
                     result.bad_header = 1'b1;
                  end else begin
                     state_in  = LPD_PAYLOAD;
                     plen_in   = header_word - HDR_BYTES;
                     remain_in = header_word - HDR_BYTES;
                  end
               end
            end
         end
         LPD_PAYLOAD: begin
            if (item_accept) begin
               result_valid          = 1'b1;
               result.payload_byte   = item_byte;
               result.last_byte      = last;
               result.payload_length = plen_ff;
               remain_in             = remain_ff - ONE_LEFT;
               if (last) begin
                  state_in = LPD_HEADER;
               end
            end
         end
         LPD_CLOSED: begin
            state_in = LPD_CLOSED;
         end
         default: begin
            state_in = LPD_HEADER;
         end
      endcase
   end

endmodule

// File: hdl/lpd_out.sv
// ----------------------------------------------------------------------------
// Length prefix deframer output stage
// Result register that holds a transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module lpd_out
   import lpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lpd_result_type      result,
   output logic                can_take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_payload_byte,
   output logic                rsp_last_byte,
   output logic [LENGTH_W-1:0] rsp_payload_length,
   output logic                rsp_bad_header
);

   logic           valid_ff, valid_in;
   lpd_result_type data_ff, data_in;

   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_payload_byte   = data_ff.payload_byte;
   assign rsp_last_byte      = data_ff.last_byte;
   assign rsp_payload_length = data_ff.payload_length;
   assign rsp_bad_header     = data_ff.bad_header;

endmodule

// File: hdl/length_prefix_deframer_core.sv
// ----------------------------------------------------------------------------
// Length prefix deframer core
// Splits a byte stream into messages framed by a 32-bit length header.
// ----------------------------------------------------------------------------
// Each message starts with four header bytes, least significant first, that
// give the total length including the header. Header bytes produce no
// transaction; every following payload byte produces one, carrying the
// payload length (total minus four) and a last mark on the final byte. A
// total length of four or less produces one bad_header transaction and closes
// the block, which then drops all bytes until reset. One byte is taken per
// clock cycle whenever the result register is empty or being drained, which
// is when req_ready is high: the parser updates its state in the accepting
// cycle and the result register presents the transaction in the next cycle.
module length_prefix_deframer_core
   import lpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_payload_byte,
   output logic                rsp_last_byte,
   output logic [LENGTH_W-1:0] rsp_payload_length,
   output logic                rsp_bad_header
);

   logic           can_take;
   logic           item_accept;
   logic           result_valid;
   lpd_result_type result;

   assign req_ready   = can_take;
   assign item_accept = req_valid && can_take;

   lpd_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (item_accept),
      .item_byte    (req_data_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   lpd_out u_out (
      .clock              (clock),
      .reset              (reset),
      .load               (result_valid),
      .result             (result),
      .can_take           (can_take),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_payload_length (rsp_payload_length),
      .rsp_bad_header     (rsp_bad_header)
   );

endmodule

// File: hdl/lpd_checker.sv
// ----------------------------------------------------------------------------
// Length prefix deframer checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "length_prefix_deframer_core_defines.svh"

module lpd_core_assert
   import lpd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BYTE_W-1:0]   rsp_payload_byte,
   input logic                rsp_last_byte,
   input logic [LENGTH_W-1:0] rsp_payload_length,
   input logic                rsp_bad_header
);

   `LPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_last_byte)
         && $stable(rsp_payload_length) && $stable(rsp_bad_header),
      "stalled transaction changed")
   `LPD_ASSERT_SAME(a_bad_zero, clock, reset, rsp_valid && rsp_bad_header,
      rsp_payload_byte == '0 && !rsp_last_byte && rsp_payload_length == '0,
      "bad header transaction has nonzero fields")
   `LPD_ASSERT_SAME(a_len_nonzero, clock, reset, rsp_valid && !rsp_bad_header,
      rsp_payload_length != '0, "payload transaction with zero length")
   `LPD_ASSERT_NEXT(a_closed_quiet, clock, reset,
      rsp_valid && rsp_ready && rsp_bad_header, !rsp_valid,
      "transaction after close")

endmodule

bind length_prefix_deframer_core lpd_core_assert u_lpd_core_assert (.*);
